/* hdl/lpbb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the layered pad backlight blinker.
// No dependencies; every other file in this folder imports it.
package lpbb_pkg;

    localparam logic [2:0] OP_SET_FRONT = 3'd0;
    localparam logic [2:0] OP_SET_BACK  = 3'd1;
    localparam logic [2:0] OP_START     = 3'd2;
    localparam logic [2:0] OP_STOP      = 3'd3;
    localparam logic [2:0] OP_CLEAR     = 3'd4;
    localparam logic [2:0] OP_TICK      = 3'd5;

    localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;

    typedef struct packed {
        logic [2:0] kind;
        logic       turn_on;
        logic [7:0] level;
        logic [5:0] pad;
        logic       clr_front;
        logic       clr_back;
        logic       clr_blink;
    } op_t;

endpackage

/* hdl/lpbb_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input words, drops those that cause no work and
// classifies the rest into queue entries. Depends on lpbb_pkg.
module lpbb_front #(
    parameter int PADS = 48
) (
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [2:0]      func,
    input  logic            turn_on,
    input  logic [7:0]      level,
    input  logic [5:0]      pad,
    input  logic            clear_front,
    input  logic            clear_back,
    input  logic            clear_blink,
    input  logic            q_full,
    output logic            q_push,
    output lpbb_pkg::op_t   q_entry
);
    import lpbb_pkg::*;

    logic pad_ok;
    logic keep;

    assign pad_ok = {1'b0, pad} < 7'(PADS);

    always_comb
    begin
        unique case (func) inside
            OP_SET_FRONT, OP_SET_BACK, OP_START, OP_STOP: keep = pad_ok;
            OP_CLEAR: keep = clear_front | clear_back | clear_blink;
            OP_TICK:  keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign in_stall = q_full;
    assign q_push   = in_valid & ~q_full & keep;

    always_comb
    begin
        q_entry.kind      = func;
        q_entry.turn_on   = turn_on;
        q_entry.level     = level;
        q_entry.pad       = pad;
        q_entry.clr_front = clear_front;
        q_entry.clr_back  = clear_back;
        q_entry.clr_blink = clear_blink;
    end

endmodule

/* hdl/lpbb_queue.sv */
`timescale 1ns / 1ps
// Two-entry operation queue between front end and back end.
// Depends on lpbb_pkg for the entry type.
module lpbb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lpbb_pkg::op_t   push_entry,
    input  logic            pop,
    output lpbb_pkg::op_t   head,
    output logic            empty,
    output logic            full
);
    import lpbb_pkg::*;

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign empty   = count_reg == 2'd0;
    assign full    = count_reg == 2'd2;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/lpbb_back.sv */
`timescale 1ns / 1ps
// Back end: level memories, blink state and the pad walk sequencer that
// turns queued operations into LED command words. Depends on lpbb_pkg.
module lpbb_back #(
    parameter int PADS = 48
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     blink_period,
    input  lpbb_pkg::op_t   head,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [5:0]      led_index,
    output logic            led_on,
    output logic [7:0]      led_level,
    output logic            last
);
    import lpbb_pkg::*;

    localparam int PIDX_W = (PADS > 1) ? $clog2(PADS) : 1;
    localparam logic [PIDX_W-1:0] IDX_LAST = PIDX_W'(PADS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_STEP = 1'b1;

    function automatic logic [8:0] layer_set(
        input logic       on,
        input logic [7:0] lvl,
        input logic [7:0] other
    );
        logic [8:0] res;
        if (on)
        begin
            res = {1'b1, (lvl > other) ? lvl : other};
        end
        else if (other != 8'd0)
        begin
            res = {1'b1, other};
        end
        else
        begin
            res = {1'b0, lvl};
        end
        return res;
    endfunction

    logic [7:0] front_mem [PADS];
    logic [7:0] back_mem  [PADS];
    logic [7:0] blink_mem [PADS];
    logic [7:0] front_rd_reg, back_rd_reg, blink_rd_reg;
    logic [PADS-1:0] front_nz_reg, back_nz_reg, blink_nz_reg;

    logic              state_reg, state_next;
    op_t               cur_reg, cur_next;
    logic [PIDX_W-1:0] idx_reg, idx_next;
    logic [7:0]        count_reg, count_next;
    logic              phase_reg, phase_next;
    logic [15:0]       elapsed_reg, elapsed_next;

    logic              out_valid_reg, out_valid_next;
    logic [5:0]        led_index_reg;
    logic              led_on_reg;
    logic [7:0]        led_level_reg;
    logic              last_reg;

    logic [PIDX_W-1:0] rd_addr, wr_addr, head_idx;
    logic              front_we, back_we, blink_we;
    logic [7:0]        front_wd, back_wd, blink_wd;

    logic [7:0]        f_val, b_val, k_val, other, b_clr, f_clr;
    logic [15:0]       elapsed_inc;
    logic [PADS-1:0]   above;
    logic              walk, emit, go, end_walk, is_last, out_free, load_out;
    logic [8:0]        cmd;

    assign head_idx    = head.pad[PIDX_W-1:0];
    assign f_val       = front_nz_reg[idx_reg] ? front_rd_reg : 8'd0;
    assign b_val       = back_nz_reg[idx_reg] ? back_rd_reg : 8'd0;
    assign k_val       = blink_nz_reg[idx_reg] ? blink_rd_reg : 8'd0;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign out_free    = ~out_valid_reg | ~out_stall;
    assign walk        = (cur_reg.kind == OP_CLEAR) | (cur_reg.kind == OP_TICK);
    assign end_walk    = ~walk | (idx_reg == IDX_LAST);
    assign b_clr       = cur_reg.clr_back ? 8'd0 : b_val;
    assign f_clr       = cur_reg.clr_front ? 8'd0 : f_val;

    always_comb
    begin
        for (int j = 0; j < PADS; j++)
        begin
            above[j] = j > int'(idx_reg);
        end
    end

    always_comb
    begin
        if (cur_reg.clr_blink)
        begin
            other = b_clr;
        end
        else if (cur_reg.clr_back)
        begin
            other = f_clr;
        end
        else
        begin
            other = b_val;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        q_pop          = 1'b0;
        rd_addr        = idx_reg;
        wr_addr        = idx_reg;
        front_we       = 1'b0;
        back_we        = 1'b0;
        blink_we       = 1'b0;
        front_wd       = 8'd0;
        back_wd        = 8'd0;
        blink_wd       = 8'd0;
        emit           = 1'b0;
        is_last        = 1'b1;
        cmd            = 9'd0;
        go             = 1'b0;
        load_out       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cur_next = head;
                rd_addr  = ((head.kind == OP_CLEAR) || (head.kind == OP_TICK)) ?
                           '0 : head_idx;
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (head.kind) inside
                        OP_SET_FRONT, OP_SET_BACK, OP_STOP:
                        begin
                            idx_next   = head_idx;
                            state_next = ST_STEP;
                        end
                        OP_CLEAR:
                        begin
                            idx_next   = '0;
                            state_next = ST_STEP;
                        end
                        OP_START:
                        begin
                            wr_addr  = head_idx;
                            blink_we = 1'b1;
                            blink_wd = head.level;
                            if (count_reg != 8'hFF)
                            begin
                                count_next = count_reg + 8'd1;
                            end
                        end
                        OP_TICK:
                        begin
                            elapsed_next = elapsed_inc;
                            if ((count_reg != 8'd0) && (elapsed_inc > blink_period))
                            begin
                                elapsed_next = 16'd0;
                                phase_next   = ~phase_reg;
                                idx_next     = '0;
                                if (blink_nz_reg != '0)
                                begin
                                    state_next = ST_STEP;
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                unique case (cur_reg.kind)
                    OP_SET_FRONT:
                    begin
                        emit     = 1'b1;
                        cmd      = layer_set(cur_reg.turn_on, cur_reg.level, b_val);
                        front_we = 1'b1;
                        front_wd = cur_reg.turn_on ? cur_reg.level : 8'd0;
                    end
                    OP_SET_BACK:
                    begin
                        emit    = 1'b1;
                        cmd     = layer_set(cur_reg.turn_on, cur_reg.level, f_val);
                        back_we = 1'b1;
                        back_wd = cur_reg.turn_on ? cur_reg.level : 8'd0;
                    end
                    OP_STOP:
                    begin
                        emit     = 1'b1;
                        cmd      = layer_set(1'b0, 8'd0, b_val);
                        front_we = 1'b1;
                        blink_we = 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        emit     = 1'b1;
                        cmd      = layer_set(1'b0, 8'd0, other);
                        is_last  = idx_reg == IDX_LAST;
                        front_we = cur_reg.clr_front | cur_reg.clr_blink;
                        back_we  = cur_reg.clr_back;
                        blink_we = cur_reg.clr_blink;
                    end
                    OP_TICK:
                    begin
                        emit     = blink_nz_reg[idx_reg];
                        cmd      = layer_set(phase_reg, k_val, b_val);
                        is_last  = (blink_nz_reg & above) == '0;
                        front_we = blink_nz_reg[idx_reg];
                        front_wd = phase_reg ? k_val : 8'd0;
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase

                go = ~emit | out_free;
                if (!go)
                begin
                    front_we = 1'b0;
                    back_we  = 1'b0;
                    blink_we = 1'b0;
                end
                else
                begin
                    load_out = emit;
                    if ((cur_reg.kind == OP_STOP) ||
                        ((cur_reg.kind == OP_CLEAR) && cur_reg.clr_blink))
                    begin
                        if (count_reg != 8'd0)
                        begin
                            count_next = count_reg - 8'd1;
                        end
                    end
                    if (end_walk)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + PIDX_W'(1);
                        rd_addr  = idx_reg + PIDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load_out | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= 8'd0;
            phase_reg     <= 1'b0;
            elapsed_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
            front_nz_reg  <= '0;
            back_nz_reg   <= '0;
            blink_nz_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
            if (front_we)
            begin
                front_nz_reg[wr_addr] <= front_wd != 8'd0;
            end
            if (back_we)
            begin
                back_nz_reg[wr_addr] <= back_wd != 8'd0;
            end
            if (blink_we)
            begin
                blink_nz_reg[wr_addr] <= blink_wd != 8'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load_out)
        begin
            led_index_reg <= 6'(idx_reg);
            led_on_reg    <= cmd[8];
            led_level_reg <= cmd[7:0];
            last_reg      <= is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_we)
        begin
            front_mem[wr_addr] <= front_wd;
        end
        if (back_we)
        begin
            back_mem[wr_addr] <= back_wd;
        end
        if (blink_we)
        begin
            blink_mem[wr_addr] <= blink_wd;
        end
        front_rd_reg <= front_mem[rd_addr];
        back_rd_reg  <= back_mem[rd_addr];
        blink_rd_reg <= blink_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign led_index = led_index_reg;
    assign led_on    = led_on_reg;
    assign led_level = led_level_reg;
    assign last      = last_reg;

endmodule

/* hdl/layered_pad_backlight_blinker.sv */
`timescale 1ns / 1ps
// Top level of the layered pad backlight blinker: blink period register,
// front end, operation queue and back end. Depends on lpbb_pkg.
//
// Input channel (in_valid / in_stall) takes one operation word: set front or
// back layer, start or stop blink, clear, or tick. Output channel
// (out_valid / out_stall) gives LED command words; last marks the final
// command caused by one operation.
// blink_period is written via blink_period_we / blink_period_wdata; the user
// must write it only while the block is idle, which the block itself does not
// enforce. It resets to 500. A set or stop passes the back end's pop state,
// with the level read, then its level update state that registers the word.
// A start and a tick without a toggle are handled in the pop state alone.
// A clear or a toggling tick walks the pads, one pad per cycle while the
// output is not stalled, through the single read port of each level memory.
// A two-entry queue lets the front end accept words while the back end
// walks; in_stall rises only when that queue is full.
// When out_stall is high while out_valid is high, the output word holds and
// the walk pauses on the pad whose command is pending.
// Reset clears all levels, the blink count, phase and tick counter at once;
// no clearing pass is needed.
module layered_pad_backlight_blinker #(
    parameter int PADS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        blink_period_we,
    input  logic [15:0] blink_period_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic        turn_on,
    input  logic [7:0]  level,
    input  logic [5:0]  pad,
    input  logic        clear_front,
    input  logic        clear_back,
    input  logic        clear_blink,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  led_index,
    output logic        led_on,
    output logic [7:0]  led_level,
    output logic        last
);
    import lpbb_pkg::*;

    logic [15:0] blink_period_reg;
    op_t         q_entry;
    op_t         q_head;
    logic        q_push, q_pop, q_empty, q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period_reg <= BLINK_PERIOD_RST;
        end
        else if (blink_period_we)
        begin
            blink_period_reg <= blink_period_wdata;
        end
    end

    lpbb_front #(
        .PADS (PADS)
    ) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .turn_on     (turn_on),
        .level       (level),
        .pad         (pad),
        .clear_front (clear_front),
        .clear_back  (clear_back),
        .clear_blink (clear_blink),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    lpbb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    lpbb_back #(
        .PADS (PADS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .blink_period (blink_period_reg),
        .head         (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .led_index    (led_index),
        .led_on       (led_on),
        .led_level    (led_level),
        .last         (last)
    );

endmodule
